// File: rtl/mersenne_twister_prng_core_assert.svh
// Assertion macros used by the generator engine RTL
`ifndef MERSENNE_TWISTER_PRNG_CORE_ASSERT_SVH
`define MERSENNE_TWISTER_PRNG_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MTPRNG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTPRNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mtprng_pkg.sv
// Types, constants and tempering function of the MT19937 generator
`timescale 1ns / 1ps
package mtprng_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned IDX_W = 10;

  localparam logic [IDX_W-1:0] FULL_IDX     = 10'd624;
  localparam logic [IDX_W-1:0] UNSEEDED_IDX = 10'd625;
  localparam logic [IDX_W-1:0] LAST_IDX     = 10'd623;
  localparam logic [IDX_W-1:0] TWIST_M      = 10'd397;

  localparam logic [31:0] INIT_MUL     = 32'd1812433253;
  localparam logic [31:0] ARRAY_SEED   = 32'd19650218;
  localparam logic [31:0] ARRAY_MUL1   = 32'd1664525;
  localparam logic [31:0] ARRAY_MUL2   = 32'd1566083941;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

  typedef enum logic [1:0] {
    OP_GEN  = 2'd0,
    OP_SEED = 2'd1,
    OP_KEY  = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic        last_key;
  } q_item_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: rtl/mtprng_front.sv
// Front end: accepts transactions, drops unused opcodes, two-entry queue
`timescale 1ns / 1ps
module mtprng_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic [31:0]           in_value,
  input  logic                  in_last_key,
  output logic                  q_valid,
  output mtprng_pkg::q_item_t   q_item,
  input  logic                  q_pop
);

  mtprng_pkg::q_item_t fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept, known_op, push;

  assign in_stall = (cnt_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign known_op = (in_opcode == mtprng_pkg::OP_GEN) || (in_opcode == mtprng_pkg::OP_SEED) ||
                    (in_opcode == mtprng_pkg::OP_KEY);
  assign push     = accept && known_op;

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r].op       <= mtprng_pkg::op_t'(in_opcode);
      fifo_r[wr_ptr_r].value    <= in_value;
      fifo_r[wr_ptr_r].last_key <= in_last_key;
    end
  end

endmodule

// File: rtl/mtprng_engine.sv
// Back end: state memory, key buffer, seeding/twist sequencer, tempered output
`timescale 1ns / 1ps
`include "mersenne_twister_prng_core_assert.svh"
module mtprng_engine #(
  parameter int KEY_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  mtprng_pkg::q_item_t  q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_random_word
);

  localparam int KW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CW = $clog2(KEY_DEPTH + 1);
  localparam int IW = mtprng_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SV_W0, ST_SV_MUL, ST_SV_WR,
    ST_AR_A, ST_AR_B, ST_AR_WRAP, ST_AR_NEXT,
    ST_TW_INIT, ST_TW_LOAD, ST_TW_A, ST_TW_B,
    ST_GEN_RD, ST_GEN_OUT
  } state_t;

  typedef enum logic [1:0] {RET_NONE, RET_ARRAY, RET_TWIST} ret_t;

  state_t        state_r, state_nxt;
  ret_t          ret_r, ret_nxt;
  logic [31:0]   seed_r, seed_nxt;
  logic [31:0]   prev_r, prev_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [10:0]   k_r, k_nxt;
  logic [KW-1:0] j_r, j_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] kcnt_r, kcnt_nxt;
  logic          phase2_r, phase2_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_word_r, out_word_nxt;

  // state memory: one write, two registered reads
  logic [31:0]   words_mem [mtprng_pkg::STATE_WORDS];
  logic          w_we;
  logic [IW-1:0] w_addr, ra_addr, rb_addr;
  logic [31:0]   w_data, ra_q, rb_q;

  // key buffer
  logic [31:0]   key_mem [KEY_DEPTH];
  logic          k_we;
  logic [KW-1:0] k_waddr;
  logic [31:0]   key_q;

  logic [31:0]   pmix, v, y;
  logic [CW-1:0] cnt_ins, j_inc;
  logic [IW-1:0] nx, mx_sum, mx;
  logic          gen_emit;

  assign pmix = prev_r ^ (prev_r >> 30);
  assign j_inc = CW'(j_r) + 1'b1;
  assign nx = (n_r == mtprng_pkg::LAST_IDX) ? '0 : n_r + 1'b1;
  assign mx_sum = n_r + mtprng_pkg::TWIST_M;
  assign mx = (mx_sum >= mtprng_pkg::FULL_IDX) ? mx_sum - mtprng_pkg::FULL_IDX : mx_sum;
  assign gen_emit = (state_r == ST_GEN_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    len_nxt       = len_r;
    kcnt_nxt      = kcnt_r;
    phase2_nxt    = phase2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    w_we          = 1'b0;
    w_addr        = n_r;
    w_data        = 32'd0;
    ra_addr       = '0;
    rb_addr       = '0;
    k_we          = 1'b0;
    k_waddr       = kcnt_r[KW-1:0];
    cnt_ins       = kcnt_r;
    v             = 32'd0;
    y             = 32'd0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            mtprng_pkg::OP_SEED: begin
              seed_nxt  = q_item.value;
              ret_nxt   = RET_NONE;
              state_nxt = ST_SV_W0;
            end
            mtprng_pkg::OP_KEY: begin
              if (kcnt_r < CW'(KEY_DEPTH)) begin
                k_we    = 1'b1;
                cnt_ins = kcnt_r + 1'b1;
              end
              kcnt_nxt = cnt_ins;
              if (q_item.last_key) begin
                kcnt_nxt = '0;
                if (cnt_ins != '0) begin
                  len_nxt   = cnt_ins;
                  seed_nxt  = mtprng_pkg::ARRAY_SEED;
                  ret_nxt   = RET_ARRAY;
                  state_nxt = ST_SV_W0;
                end
              end
            end
            mtprng_pkg::OP_GEN: begin
              if (idx_r == mtprng_pkg::UNSEEDED_IDX) begin
                seed_nxt  = mtprng_pkg::DEFAULT_SEED;
                ret_nxt   = RET_TWIST;
                state_nxt = ST_SV_W0;
              end else if (idx_r >= mtprng_pkg::FULL_IDX) begin
                state_nxt = ST_TW_INIT;
              end else begin
                state_nxt = ST_GEN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // linear initializer
      ST_SV_W0: begin
        w_we      = 1'b1;
        w_addr    = '0;
        w_data    = seed_r;
        prev_nxt  = seed_r;
        n_nxt     = IW'(1);
        state_nxt = ST_SV_MUL;
      end
      ST_SV_MUL: begin
        prod_nxt  = pmix * mtprng_pkg::INIT_MUL;
        state_nxt = ST_SV_WR;
      end
      ST_SV_WR: begin
        v        = prod_r + 32'(n_r);
        w_we     = 1'b1;
        w_data   = v;
        prev_nxt = v;
        if (n_r == mtprng_pkg::LAST_IDX) begin
          idx_nxt = mtprng_pkg::FULL_IDX;
          case (ret_r)
            RET_TWIST: state_nxt = ST_TW_INIT;
            RET_ARRAY: begin
              prev_nxt   = mtprng_pkg::ARRAY_SEED;
              n_nxt      = IW'(1);
              j_nxt      = '0;
              k_nxt      = (11'(len_r) > 11'(mtprng_pkg::STATE_WORDS)) ? 11'(len_r) :
                           11'(mtprng_pkg::STATE_WORDS);
              phase2_nxt = 1'b0;
              state_nxt  = ST_AR_A;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = ST_SV_MUL;
        end
      end

      // array seeding, both passes
      ST_AR_A: begin
        ra_addr   = n_r;
        prod_nxt  = pmix * (phase2_r ? mtprng_pkg::ARRAY_MUL2 : mtprng_pkg::ARRAY_MUL1);
        state_nxt = ST_AR_B;
      end
      ST_AR_B: begin
        if (phase2_r) v = (ra_q ^ prod_r) - 32'(n_r);
        else          v = (ra_q ^ prod_r) + key_q + 32'(j_r);
        w_we     = 1'b1;
        w_data   = v;
        prev_nxt = v;
        k_nxt    = k_r - 1'b1;
        j_nxt    = (j_inc >= len_r) ? '0 : KW'(j_inc);
        if (n_r == mtprng_pkg::LAST_IDX) begin
          n_nxt     = IW'(1);
          state_nxt = ST_AR_WRAP;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = (k_r == 11'd1) ? ST_AR_NEXT : ST_AR_A;
        end
      end
      ST_AR_WRAP: begin
        w_we      = 1'b1;
        w_addr    = '0;
        w_data    = prev_r;
        state_nxt = (k_r == 11'd0) ? ST_AR_NEXT : ST_AR_A;
      end
      ST_AR_NEXT: begin
        if (!phase2_r) begin
          phase2_nxt = 1'b1;
          k_nxt      = 11'(mtprng_pkg::STATE_WORDS - 1);
          state_nxt  = ST_AR_A;
        end else begin
          w_we      = 1'b1;
          w_addr    = '0;
          w_data    = mtprng_pkg::HIGH_BIT;
          idx_nxt   = mtprng_pkg::FULL_IDX;
          state_nxt = ST_IDLE;
        end
      end

      // in-place twist of all words, current word carried in cur_r
      ST_TW_INIT: begin
        n_nxt     = '0;
        state_nxt = ST_TW_LOAD;
      end
      ST_TW_LOAD: begin
        cur_nxt   = ra_q;
        state_nxt = ST_TW_A;
      end
      ST_TW_A: begin
        ra_addr   = nx;
        rb_addr   = mx;
        state_nxt = ST_TW_B;
      end
      ST_TW_B: begin
        y       = (cur_r & mtprng_pkg::HIGH_BIT) | (ra_q & mtprng_pkg::LOW_BITS);
        v       = rb_q ^ (y >> 1) ^ (y[0] ? mtprng_pkg::TWIST_MATRIX : 32'd0);
        w_we    = 1'b1;
        w_data  = v;
        cur_nxt = ra_q;
        if (n_r == mtprng_pkg::LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_GEN_RD;
        end else begin
          n_nxt     = n_r + 1'b1;
          state_nxt = ST_TW_A;
        end
      end

      ST_GEN_RD: begin
        ra_addr   = idx_r;
        state_nxt = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        ra_addr = idx_r;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtprng_pkg::temper(ra_q);
          idx_nxt       = idx_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= RET_NONE;
      idx_r       <= mtprng_pkg::UNSEEDED_IDX;
      kcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      idx_r       <= idx_nxt;
      kcnt_r      <= kcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    seed_r     <= seed_nxt;
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    len_r      <= len_nxt;
    phase2_r   <= phase2_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (w_we) words_mem[w_addr] <= w_data;
    ra_q <= words_mem[ra_addr];
    rb_q <= words_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (k_we) key_mem[k_waddr] <= q_item.value;
    key_q <= key_mem[j_r];
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  `MTPRNG_ASSERT_NOW(a_idx_range, 1'b1, idx_r <= mtprng_pkg::UNSEEDED_IDX, "word index out of range")
  `MTPRNG_ASSERT_NOW(a_kcnt_range, 1'b1, kcnt_r <= CW'(KEY_DEPTH), "key count over depth")
  `MTPRNG_ASSERT_NOW(a_pop_valid, q_pop, q_valid && state_r == ST_IDLE, "pop without queued item")
  `MTPRNG_ASSERT_NEXT(a_emit, gen_emit, out_valid_r && idx_r != mtprng_pkg::UNSEEDED_IDX, "no result")

endmodule

// File: rtl/mersenne_twister_prng_core.sv
// Value seeding writes all 624 words in turn; key seeding then adds two passes over the state,
// of max(624,n) and 623 words, plus a write of word zero on each wrap; a generate pops,
// does a registered read and outputs, after a twist of all 624 words when the index runs out
// (every 624th word; an unseeded first generate seeds with 5489 before that twist).
// Throughput: one transaction at a time; a generate holds in its output step while out_stall blocks.
// Reset: synchronous active-low; index marks unseeded, key buffer and queue empty.
`timescale 1ns / 1ps
module mersenne_twister_prng_core #(
  parameter int KEY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_value,
  input  logic        in_last_key,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_word
);

  logic                q_valid, q_pop;
  mtprng_pkg::q_item_t q_item;

  mtprng_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_value    (in_value),
    .in_last_key (in_last_key),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  mtprng_engine #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word)
  );

endmodule
